@@ src/sbsp_pkg.sv @@
// Shared types and constants of the shader blob stream parser.
package sbsp_pkg;

    localparam int unsigned TOTAL_LEN_W = 13;

    localparam logic [3:0] KIND_INSTR      = 4'd0;
    localparam logic [3:0] KIND_UNIFORM    = 4'd1;
    localparam logic [3:0] KIND_ATTR       = 4'd2;
    localparam logic [3:0] KIND_OUTPUT     = 4'd3;
    localparam logic [3:0] KIND_CONST_REG  = 4'd4;
    localparam logic [3:0] KIND_CONST_VAL  = 4'd5;
    localparam logic [3:0] KIND_WINDOW_REG = 4'd6;
    localparam logic [3:0] KIND_WINDOW_VAL = 4'd7;
    localparam logic [3:0] KIND_HEADER     = 4'd8;

    localparam logic [1:0] LAST_WORD_BYTE = 2'd3;

    typedef struct packed {
        logic                   word_byte;
        logic [1:0]             word_pos;
        logic [3:0]             kind;
        logic [7:0]             index;
        logic [7:0]             data;
        logic                   done_res;
        logic                   error;
        logic [TOTAL_LEN_W-1:0] total_length;
    } cmd_t;

endpackage

@@ src/sbsp_if.sv @@
// Handshake channel interfaces for blob bytes and parse results.
interface sbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface sbsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  index;
    logic [31:0] value;
    logic        done_res;
    logic        error;
    logic [12:0] total_length;

    modport source (output valid, output kind, output index, output value,
                    output done_res, output error, output total_length, input ready);
    modport sink   (input valid, input kind, input index, input value,
                    input done_res, input error, input total_length, output ready);
endinterface

@@ src/sbsp_front.sv @@
// Parser front end: tracks blob phase, counts and length, and classifies each byte.
module sbsp_front #(
    parameter int unsigned MAX_INSTRUCTIONS = 64,
    parameter int unsigned MAX_REGISTERS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              draw_ext_mask_we,
    input  logic [7:0]        draw_ext_mask_wdata,
    input  logic              byte_valid,
    input  logic [7:0]        data_byte,
    input  logic              start_req,
    input  logic              queue_full,
    output logic              byte_ready,
    output logic              cmd_push,
    output sbsp_pkg::cmd_t    cmd
);
    import sbsp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HDR   = 4'd1,
        PH_INSTR = 4'd2,
        PH_UREG  = 4'd3,
        PH_AREG  = 4'd4,
        PH_OREG  = 4'd5,
        PH_CREG  = 4'd6,
        PH_CVAL  = 4'd7,
        PH_VARY  = 4'd8,
        PH_WCNT  = 4'd9,
        PH_WREG  = 4'd10,
        PH_WVAL  = 4'd11,
        PH_HALT  = 4'd12
    } phase_t;

    typedef logic [5:0][7:0] counts_t;

    localparam logic [7:0] MAX_INSTR_LIM = 8'(MAX_INSTRUCTIONS);
    localparam logic [7:0] MAX_REG_LIM   = 8'(MAX_REGISTERS);
    localparam logic [7:0] HDR_LAST_CNT  = 8'd5;
    localparam logic [7:0] HDR_VARY      = 8'd6;
    localparam logic [7:0] HDR_WCNT      = 8'd7;

    phase_t                 phase_reg, phase_next;
    counts_t                counts_reg, counts_next;
    logic [7:0]             elem_reg, elem_next;
    logic [1:0]             biw_reg, biw_next;
    logic [TOTAL_LEN_W-1:0] len_reg, len_next;
    logic                   ext_reg, ext_next;
    logic [7:0]             mask_reg;

    phase_t                 cur_phase;
    counts_t                cur_counts;
    logic [7:0]             cur_elem;
    logic [1:0]             cur_biw;
    logic [TOTAL_LEN_W-1:0] cur_len;
    logic                   cur_ext;
    logic                   take;
    logic                   word_phase;
    logic [7:0]             lim;

    function automatic logic [7:0] count_for(phase_t p, counts_t c, logic e);
        logic [7:0] r;
        case (p)
            PH_INSTR:          r = c[0];
            PH_UREG:           r = c[1];
            PH_AREG:           r = c[2];
            PH_OREG:           r = c[3];
            PH_CREG, PH_CVAL:  r = c[4];
            PH_VARY, PH_WCNT:  r = {7'd0, e};
            PH_WREG, PH_WVAL:  r = c[5];
            default:           r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic phase_t seek(phase_t from, counts_t c, logic e);
        phase_t r;
        logic   found;
        r = PH_HALT;
        found = 1'b0;
        for (int p = PH_INSTR; p <= PH_WVAL; p++) begin
            if (!found && (4'(p) >= from) && (count_for(phase_t'(4'(p)), c, e) != 8'd0)) begin
                r = phase_t'(4'(p));
                found = 1'b1;
            end
        end
        return r;
    endfunction

    assign byte_ready = !queue_full;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        if (start_req) begin
            cur_phase  = PH_HDR;
            cur_counts = '0;
            cur_elem   = 8'd0;
            cur_biw    = 2'd0;
            cur_len    = '0;
            cur_ext    = 1'b0;
        end else begin
            cur_phase  = phase_reg;
            cur_counts = counts_reg;
            cur_elem   = elem_reg;
            cur_biw    = biw_reg;
            cur_len    = len_reg;
            cur_ext    = ext_reg;
        end

        phase_next  = cur_phase;
        counts_next = cur_counts;
        elem_next   = cur_elem;
        biw_next    = cur_biw;
        len_next    = cur_len;
        ext_next    = cur_ext;
        word_phase  = (cur_phase == PH_INSTR) || (cur_phase == PH_CVAL) ||
                      (cur_phase == PH_WVAL);
        lim         = (cur_elem == 8'd0) ? MAX_INSTR_LIM : MAX_REG_LIM;

        cmd_push          = 1'b0;
        cmd.word_byte     = 1'b0;
        cmd.word_pos      = cur_biw;
        cmd.kind          = KIND_HEADER;
        cmd.index         = cur_elem;
        cmd.data          = data_byte;
        cmd.done_res      = 1'b0;
        cmd.error         = 1'b0;
        cmd.total_length  = cur_len + TOTAL_LEN_W'(1);

        if (cur_phase != PH_IDLE && cur_phase != PH_HALT) begin
            cmd_push = take;
            len_next = cur_len + TOTAL_LEN_W'(1);
            case (cur_phase)
                PH_HDR:
                begin
                    if (cur_elem < HDR_LAST_CNT) begin
                        counts_next[cur_elem[2:0]] = data_byte;
                        if (data_byte > lim) begin
                            cmd.error  = 1'b1;
                            phase_next = PH_HALT;
                        end else begin
                            elem_next = cur_elem + 8'd1;
                        end
                    end else begin
                        ext_next     = (data_byte & mask_reg) != 8'd0;
                        elem_next    = 8'd0;
                        phase_next   = seek(PH_INSTR, counts_next, ext_next);
                        cmd.done_res = (phase_next == PH_HALT);
                    end
                end
                PH_VARY:
                begin
                    cmd.index  = HDR_VARY;
                    phase_next = seek(PH_WCNT, cur_counts, cur_ext);
                end
                PH_WCNT:
                begin
                    cmd.index      = HDR_WCNT;
                    counts_next[5] = data_byte;
                    if (data_byte > MAX_REG_LIM) begin
                        cmd.error  = 1'b1;
                        phase_next = PH_HALT;
                    end else begin
                        elem_next    = 8'd0;
                        phase_next   = seek(PH_WREG, counts_next, cur_ext);
                        cmd.done_res = (phase_next == PH_HALT);
                    end
                end
                default:
                begin
                    cmd.word_byte = word_phase;
                    case (cur_phase)
                        PH_INSTR: cmd.kind = KIND_INSTR;
                        PH_UREG:  cmd.kind = KIND_UNIFORM;
                        PH_AREG:  cmd.kind = KIND_ATTR;
                        PH_OREG:  cmd.kind = KIND_OUTPUT;
                        PH_CREG:  cmd.kind = KIND_CONST_REG;
                        PH_CVAL:  cmd.kind = KIND_CONST_VAL;
                        PH_WREG:  cmd.kind = KIND_WINDOW_REG;
                        default:  cmd.kind = KIND_WINDOW_VAL;
                    endcase
                    if (word_phase && cur_biw != LAST_WORD_BYTE) begin
                        biw_next = cur_biw + 2'd1;
                    end else begin
                        biw_next = 2'd0;
                        if ({1'b0, cur_elem} + 9'd1 >=
                            {1'b0, count_for(cur_phase, cur_counts, cur_ext)}) begin
                            elem_next    = 8'd0;
                            phase_next   = seek(phase_t'(cur_phase + 4'd1), cur_counts, cur_ext);
                            cmd.done_res = (phase_next == PH_HALT);
                        end else begin
                            elem_next = cur_elem + 8'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_IDLE;
            counts_reg <= '0;
            elem_reg   <= 8'd0;
            biw_reg    <= 2'd0;
            len_reg    <= '0;
            ext_reg    <= 1'b0;
            mask_reg   <= 8'd1;
        end else begin
            if (draw_ext_mask_we) begin
                mask_reg <= draw_ext_mask_wdata;
            end
            if (take) begin
                phase_reg  <= phase_next;
                counts_reg <= counts_next;
                elem_reg   <= elem_next;
                biw_reg    <= biw_next;
                len_reg    <= len_next;
                ext_reg    <= ext_next;
            end
        end
    end

endmodule

@@ src/sbsp_fifo.sv @@
// Short queue of classified byte commands between the front end and the back end.
module sbsp_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sbsp_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output sbsp_pkg::cmd_t pop_data,
    output logic           empty
);
    import sbsp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ src/sbsp_back.sv @@
// Parser back end: assembles little-endian words and holds the result beat.
module sbsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_avail,
    input  sbsp_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    sbsp_out_if.source        out_ch
);
    import sbsp_pkg::*;

    logic [23:0]            acc_reg, acc_next;
    logic                   valid_reg;
    logic [3:0]             kind_reg;
    logic [7:0]             index_reg;
    logic [31:0]            value_reg;
    logic                   done_reg;
    logic                   error_reg;
    logic [TOTAL_LEN_W-1:0] len_reg;
    logic                   partial;
    logic [31:0]            value_next;

    assign cmd_pop = cmd_avail && (!valid_reg || out_ch.ready);
    assign partial = cmd.word_byte && (cmd.word_pos != LAST_WORD_BYTE);

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.word_pos)
            2'd0:    acc_next = {16'd0, cmd.data};
            2'd1:    acc_next[15:8] = cmd.data;
            2'd2:    acc_next[23:16] = cmd.data;
            default: acc_next = acc_reg;
        endcase
        value_next = cmd.word_byte ? {cmd.data, acc_reg} : {24'd0, cmd.data};
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && partial) begin
            acc_reg <= acc_next;
        end
        if (cmd_pop && !partial) begin
            kind_reg  <= cmd.kind;
            index_reg <= cmd.index;
            value_reg <= value_next;
            done_reg  <= cmd.done_res;
            error_reg <= cmd.error;
            len_reg   <= cmd.total_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (cmd_pop) begin
            valid_reg <= !partial;
        end else if (out_ch.ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.kind         = kind_reg;
    assign out_ch.index        = index_reg;
    assign out_ch.value        = value_reg;
    assign out_ch.done_res     = done_reg;
    assign out_ch.error        = error_reg;
    assign out_ch.total_length = len_reg;

endmodule

@@ src/shader_blob_stream_parser.sv @@
// Top level of the shader blob stream parser.
// The parser takes one blob byte per cycle while its command queue has room and gives at most one result beat per byte.
// A byte is accepted in the cycle it arrives as long as the two-entry command queue has
// room, so with a sink that is always ready the sustained rate is one byte per cycle.
// An accepted byte is registered in the command queue, and its result then in the back end's
// output register, before it appears on the output channel. The front end's phase and count
// update is the loop that sets the byte rate.
module shader_blob_stream_parser #(
    parameter int unsigned MAX_INSTRUCTIONS = 64,
    parameter int unsigned MAX_REGISTERS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        draw_ext_mask_we,
    input  logic [7:0]  draw_ext_mask_wdata,
    sbsp_in_if.sink     in_ch,
    sbsp_out_if.source  out_ch
);
    import sbsp_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic cmd_push;
    logic queue_full;
    logic queue_empty;
    logic cmd_pop;

    sbsp_front #(
        .MAX_INSTRUCTIONS (MAX_INSTRUCTIONS),
        .MAX_REGISTERS    (MAX_REGISTERS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .draw_ext_mask_we    (draw_ext_mask_we),
        .draw_ext_mask_wdata (draw_ext_mask_wdata),
        .byte_valid          (in_ch.valid),
        .data_byte           (in_ch.data_byte),
        .start_req           (in_ch.start_req),
        .queue_full          (queue_full),
        .byte_ready          (in_ch.ready),
        .cmd_push            (cmd_push),
        .cmd                 (front_cmd)
    );

    sbsp_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .pop_data  (back_cmd),
        .empty     (queue_empty)
    );

    sbsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (!queue_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

@@ dv/shader_blob_stream_parser_tb.sv @@
// Self-checking testbench for the shader blob stream parser with a scoreboard class.
`timescale 1ns / 100ps

module shader_blob_stream_parser_tb;
    import sbsp_pkg::*;

    localparam int MAX_INSTR = 64;
    localparam int MAX_REG   = 16;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_HDR   = 4'd1;
    localparam logic [3:0] ST_INSTR = 4'd2;
    localparam logic [3:0] ST_UREG  = 4'd3;
    localparam logic [3:0] ST_AREG  = 4'd4;
    localparam logic [3:0] ST_OREG  = 4'd5;
    localparam logic [3:0] ST_CREG  = 4'd6;
    localparam logic [3:0] ST_CVAL  = 4'd7;
    localparam logic [3:0] ST_VARY  = 4'd8;
    localparam logic [3:0] ST_WCNT  = 4'd9;
    localparam logic [3:0] ST_WREG  = 4'd10;
    localparam logic [3:0] ST_WVAL  = 4'd11;
    localparam logic [3:0] ST_HALT  = 4'd12;

    localparam logic [7:0] HDR_EXT = 8'd5;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  index;
        logic [31:0] value;
        logic        done_res;
        logic        error;
        logic [12:0] total_length;
    } blob_result_t;

    class blob_scoreboard;
        logic [7:0]   mask = 8'h01;
        logic [3:0]   phase = ST_IDLE;
        logic [7:0]   counts[6];
        logic [7:0]   elem;
        logic [1:0]   word_pos;
        logic [23:0]  acc;
        logic [12:0]  byte_count;
        logic         ext_on;
        blob_result_t pending[$];
        int           errors = 0;
        int           checked = 0;

        function void clear_parse();
            foreach (counts[i])
                counts[i] = 8'd0;
            elem = 8'd0;
            word_pos = 2'd0;
            acc = 24'd0;
            byte_count = 13'd0;
            ext_on = 1'b0;
        endfunction

        function logic [7:0] count_for(logic [3:0] ph);
            case (ph)
                ST_INSTR:         return counts[0];
                ST_UREG:          return counts[1];
                ST_AREG:          return counts[2];
                ST_OREG:          return counts[3];
                ST_CREG, ST_CVAL: return counts[4];
                ST_VARY, ST_WCNT: return {7'd0, ext_on};
                ST_WREG, ST_WVAL: return counts[5];
                default:          return 8'd0;
            endcase
        endfunction

        function logic [3:0] seek(logic [3:0] ph);
            while (ph <= ST_WVAL && count_for(ph) == 8'd0)
                ph = ph + 4'd1;
            return ph;
        endfunction

        function logic [3:0] kind_of(logic [3:0] ph);
            case (ph)
                ST_INSTR: return KIND_INSTR;
                ST_UREG:  return KIND_UNIFORM;
                ST_AREG:  return KIND_ATTR;
                ST_OREG:  return KIND_OUTPUT;
                ST_CREG:  return KIND_CONST_REG;
                ST_CVAL:  return KIND_CONST_VAL;
                ST_WREG:  return KIND_WINDOW_REG;
                default:  return KIND_WINDOW_VAL;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            blob_result_t r;
            logic emit;
            int lim;
            if (start)
            begin
                clear_parse();
                phase = ST_HDR;
            end
            if (phase == ST_IDLE || phase >= ST_HALT)
                return;
            byte_count = byte_count + 13'd1;
            r = '0;
            emit = 1'b1;
            case (phase)
                ST_HDR:
                begin
                    r.kind = KIND_HEADER;
                    r.index = elem;
                    r.value = {24'd0, b};
                    if (elem < HDR_EXT)
                    begin
                        lim = (elem == 8'd0) ? MAX_INSTR : MAX_REG;
                        counts[elem] = b;
                        if (int'(b) > lim)
                        begin
                            r.error = 1'b1;
                            phase = ST_HALT;
                        end
                        else
                            elem = elem + 8'd1;
                    end
                    else
                    begin
                        ext_on = (b & mask) != 8'd0;
                        elem = 8'd0;
                        phase = seek(ST_INSTR);
                        r.done_res = (phase == ST_HALT);
                    end
                end
                ST_VARY:
                begin
                    r.kind = KIND_HEADER;
                    r.index = 8'd6;
                    r.value = {24'd0, b};
                    phase = seek(ST_WCNT);
                end
                ST_WCNT:
                begin
                    r.kind = KIND_HEADER;
                    r.index = 8'd7;
                    r.value = {24'd0, b};
                    counts[5] = b;
                    if (int'(b) > MAX_REG)
                    begin
                        r.error = 1'b1;
                        phase = ST_HALT;
                    end
                    else
                    begin
                        elem = 8'd0;
                        phase = seek(ST_WREG);
                        r.done_res = (phase == ST_HALT);
                    end
                end
                default:
                begin
                    if (phase == ST_INSTR || phase == ST_CVAL || phase == ST_WVAL)
                    begin
                        if (word_pos != LAST_WORD_BYTE)
                        begin
                            acc = acc | (24'(b) << (8 * word_pos));
                            word_pos = word_pos + 2'd1;
                            emit = 1'b0;
                        end
                        else
                        begin
                            r.value = {b, acc};
                            acc = 24'd0;
                            word_pos = 2'd0;
                        end
                    end
                    else
                        r.value = {24'd0, b};
                    if (emit)
                    begin
                        r.kind = kind_of(phase);
                        r.index = elem;
                        if (int'(elem) + 1 >= int'(count_for(phase)))
                        begin
                            elem = 8'd0;
                            phase = seek(phase + 4'd1);
                            r.done_res = (phase == ST_HALT);
                        end
                        else
                            elem = elem + 8'd1;
                    end
                end
            endcase
            if (emit)
            begin
                r.total_length = byte_count;
                pending.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(blob_result_t got);
            blob_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0h index %0h value %0h",
                         $time, got.kind, got.index, got.value);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("index", 32'(want.index), 32'(got.index));
            compare_field("value", want.value, got.value);
            compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
            compare_field("error", 32'(want.error), 32'(got.error));
            compare_field("total_length", 32'(want.total_length), 32'(got.total_length));
            checked++;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       mask_we;
    logic [7:0] mask_wdata;
    logic [7:0] cur_mask;
    logic       calm;
    logic [7:0] blob_bytes[$];
    int         byte_total;
    int         blob_total;

    blob_scoreboard book;

    sbsp_in_if  in_ch ();
    sbsp_out_if out_ch ();

    shader_blob_stream_parser #(
        .MAX_INSTRUCTIONS (MAX_INSTR),
        .MAX_REGISTERS    (MAX_REG)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .draw_ext_mask_we    (mask_we),
        .draw_ext_mask_wdata (mask_wdata),
        .in_ch               (in_ch),
        .out_ch              (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        blob_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind = out_ch.kind;
            got.index = out_ch.index;
            got.value = out_ch.value;
            got.done_res = out_ch.done_res;
            got.error = out_ch.error;
            got.total_length = out_ch.total_length;
            book.check_result(got);
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b, input logic start);
        if (!calm && $urandom_range(99) < 27)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.start_req <= start;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        book.note_byte(b, start);
        byte_total++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [7:0] m);
        wait_drained();
        mask_we <= 1'b1;
        mask_wdata <= m;
        @(posedge clk);
        mask_we <= 1'b0;
        book.mask = m;
        cur_mask = m;
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            blob_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic make_blob(input int ic, input int uc, input int ac, input int oc,
                             input int cc, input logic [7:0] ext, input int wc);
        blob_bytes.delete();
        blob_bytes.push_back(8'(ic));
        blob_bytes.push_back(8'(uc));
        blob_bytes.push_back(8'(ac));
        blob_bytes.push_back(8'(oc));
        blob_bytes.push_back(8'(cc));
        blob_bytes.push_back(ext);
        if (ic > MAX_INSTR || uc > MAX_REG || ac > MAX_REG || oc > MAX_REG || cc > MAX_REG)
        begin
            push_random(2);
            return;
        end
        push_random(4 * ic + uc + ac + oc + 5 * cc);
        if ((ext & cur_mask) != 8'd0)
        begin
            push_random(1);
            blob_bytes.push_back(8'(wc));
            push_random((wc > MAX_REG) ? 2 : 5 * wc);
        end
    endtask

    task automatic send_blob(input int cut);
        for (int i = 0; i < cut; i++)
            put_byte(blob_bytes[i], i == 0);
        blob_total++;
    endtask

    function automatic int pick_count(input int lim);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return lim;
        if (r < 20)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    task automatic random_blob();
        int sel;
        int cut;
        int c[5];
        int wc;
        int which;
        logic [7:0] ext;
        sel = $urandom_range(99);
        c[0] = pick_count(MAX_INSTR);
        for (int i = 1; i < 5; i++)
            c[i] = pick_count(MAX_REG);
        wc = pick_count(MAX_REG);
        ext = 8'($urandom_range(0, 255));
        if (sel < 8)
        begin
            which = $urandom_range(0, 4);
            c[which] = $urandom_range((which == 0 ? MAX_INSTR : MAX_REG) + 1, 255);
        end
        else if (sel < 14)
        begin
            ext = ext | cur_mask;
            wc = $urandom_range(MAX_REG + 1, 255);
        end
        make_blob(c[0], c[1], c[2], c[3], c[4], ext, wc);
        cut = blob_bytes.size();
        if (sel >= 88)
            cut = $urandom_range(1, cut);
        send_blob(cut);
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin
        logic [7:0] masks[4];
        book = new();
        masks = '{8'hFF, 8'h00, 8'h80, 8'h01};
        masks[3] = 8'($urandom_range(0, 255));
        calm = 1'b0;
        cur_mask = 8'h01;
        byte_total = 0;
        blob_total = 0;
        rst_n <= 1'b0;
        mask_we <= 1'b0;
        mask_wdata <= 8'h00;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.start_req <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mask(8'h01);

        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        make_blob(0, 0, 0, 0, 0, 8'h00, 0);
        send_blob(6);
        make_blob(MAX_INSTR + 1, 0, 0, 0, 0, 8'h00, 0);
        send_blob(2);
        make_blob(MAX_INSTR, MAX_REG + 1, 0, 0, 0, 8'h00, 0);
        send_blob(2);
        make_blob(0, 0, 0, 0, 0, 8'h01, 0);
        send_blob(8);
        make_blob(0, 0, 0, 0, 0, 8'hFF, MAX_REG + 1);
        send_blob(8);

        for (int p = 0; p < 4; p++)
        begin
            write_mask(masks[p]);
            calm = (p == 2);
            while (byte_total < 28 + 250 * (p + 1))
                random_blob();
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        $display("summary: %0d bytes in %0d blobs under four extension masks, %0d results checked",
                 byte_total, blob_total, book.checked);
        if (book.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
